// File: rtl/core/itda_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the signed integer to decimal ASCII converter.
// No dependencies; every other file of the block imports this package.
package itda_pkg;

    localparam int VALUE_W     = 32;
    localparam int MAX_DIGITS  = 10;
    localparam int DIGIT_W     = 4;
    localparam int DIGITS_W    = MAX_DIGITS * DIGIT_W;
    localparam int NDIG_W      = $clog2(MAX_DIGITS + 1);
    localparam int CHAR_W      = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reciprocal of ten scaled by 2^35, rounded up; exact quotient for 32-bit inputs.
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    // One converted number. Digits are packed with the most significant digit
    // in the lowest nibble, so the emitter shifts right by one nibble a step.
    typedef struct packed {
        logic                neg;
        logic [NDIG_W-1:0]   ndig;
        logic [DIGITS_W-1:0] digits;
    } t_entry;

endpackage

// File: rtl/core/itda_front.sv
`timescale 1ns / 1ps
// Front end: accepts a value, takes its magnitude and peels off decimal digits
// one per cycle by reciprocal multiplication. Depends on itda_pkg.
module itda_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [itda_pkg::VALUE_W-1:0]   i_value,
    output logic                           o_push,
    output itda_pkg::t_entry               o_entry,
    input  logic                           i_space
);
    import itda_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]             r_state, n_state;
    logic                   r_neg;
    logic [VALUE_W-1:0]     r_mag;
    logic [NDIG_W-1:0]      r_ndig;
    logic [DIGITS_W-1:0]    r_digits;

    logic [2*VALUE_W-1:0]   prod;
    logic [VALUE_W-1:0]     quot;
    logic [VALUE_W+3:0]     quot_x10;
    logic [DIGIT_W-1:0]     rem;
    logic [NDIG_W-1:0]      ndig_inc;
    logic [DIGITS_W-1:0]    digits_shift;
    logic                   conv_done;
    logic                   accept;

    assign prod         = {{VALUE_W{1'b0}}, r_mag} * {{VALUE_W{1'b0}}, RECIP_TEN};
    assign quot         = {{RECIP_SHIFT-VALUE_W{1'b0}}, prod[2*VALUE_W-1:RECIP_SHIFT]};
    assign quot_x10     = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    assign rem          = r_mag[DIGIT_W-1:0] - quot_x10[DIGIT_W-1:0];
    assign ndig_inc     = r_ndig + NDIG_W'(1);
    assign digits_shift = {r_digits[DIGITS_W-DIGIT_W-1:0], rem};
    assign conv_done    = (quot == '0);

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_entry.neg = r_neg;
        if (r_state == ST_CONV) begin
            o_entry.ndig   = ndig_inc;
            o_entry.digits = digits_shift;
        end else begin
            o_entry.ndig   = r_ndig;
            o_entry.digits = r_digits;
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (conv_done) begin
                    if (i_space) begin
                        o_push  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                if (i_space) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg    <= i_value[VALUE_W-1];
            r_mag    <= i_value[VALUE_W-1] ? (~i_value + VALUE_W'(1)) : i_value;
            r_ndig   <= '0;
            r_digits <= '0;
        end else if (r_state == ST_CONV) begin
            r_mag    <= quot;
            r_ndig   <= ndig_inc;
            r_digits <= digits_shift;
        end
    end

endmodule

// File: rtl/core/itda_queue.sv
`timescale 1ns / 1ps
// Short queue of converted numbers between the front end and the emitter.
// Depends on itda_pkg.
module itda_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  itda_pkg::t_entry i_entry,
    output logic             o_space,
    input  logic             i_pop,
    output logic             o_avail,
    output itda_pkg::t_entry o_entry
);
    import itda_pkg::*;

    t_entry              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_space = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_entry = r_slots[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            if (i_pop)  r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slots[r_wp] <= i_entry;
    end

endmodule

// File: rtl/core/itda_back.sv
`timescale 1ns / 1ps
// Emitter: sends the characters of each queued number through an output register,
// sign first, one per cycle while the receiver is ready. Depends on itda_pkg.
module itda_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_avail,
    input  itda_pkg::t_entry              i_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [itda_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last_char
);
    import itda_pkg::*;

    logic                  r_busy;
    logic                  r_neg_pend;
    logic [NDIG_W-1:0]     r_left;
    logic [DIGITS_W-1:0]   r_digits;
    logic                  r_ovalid;
    logic [CHAR_W-1:0]     r_char;
    logic                  r_last;

    logic                  advance;
    logic                  finishing;

    assign advance   = r_busy && (!r_ovalid || i_ready);
    assign finishing = !r_neg_pend && (r_left == NDIG_W'(1));
    assign o_pop     = i_avail && (!r_busy || (advance && finishing));

    assign o_valid     = r_ovalid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (advance && finishing) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_neg_pend) begin
                r_char <= ASCII_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= ASCII_ZERO + {{CHAR_W-DIGIT_W{1'b0}}, r_digits[DIGIT_W-1:0]};
                r_last <= finishing;
            end
        end
        if (o_pop) begin
            r_neg_pend <= i_entry.neg;
            r_left     <= i_entry.ndig;
            r_digits   <= i_entry.digits;
        end else if (advance) begin
            if (r_neg_pend) begin
                r_neg_pend <= 1'b0;
            end else begin
                r_left   <= r_left - NDIG_W'(1);
                r_digits <= {{DIGIT_W{1'b0}}, r_digits[DIGITS_W-1:DIGIT_W]};
            end
        end
    end

endmodule

// File: rtl/core/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Converts a signed 32-bit integer into its decimal ASCII characters, one character
// per output request, most significant first, with a minus sign ahead of negative
// numbers and the final character flagged by o_last_char; zero gives a single '0'
// and the most negative value gives "-2147483648". The front end takes one request
// and then produces one decimal digit per cycle with a 32x32 reciprocal multiply.
// The emitter sends one character per cycle while the receiver is ready; a number
// has 1 to 11 characters. A two-entry queue sits between them, so the front end
// works on the next number while the emitter is still sending the previous one.
// The output is registered.
// Depends on itda_pkg, itda_front, itda_queue and itda_back.
module signed_int_to_decimal_ascii (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [itda_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [itda_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last_char
);
    import itda_pkg::*;

    // Handoff between the front end and the queue.
    logic   push;
    logic   space;
    t_entry front_entry;

    // Handoff between the queue and the emitter.
    logic   pop;
    logic   avail;
    t_entry queue_entry;

    // Front end: sign, magnitude and digit extraction.
    itda_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_push  (push),
        .o_entry (front_entry),
        .i_space (space)
    );

    // Decouples digit extraction from character emission.
    itda_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_space (space),
        .i_pop   (pop),
        .o_avail (avail),
        .o_entry (queue_entry)
    );

    // Emitter: one character per cycle, while the receiver is ready, into the output register.
    itda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (avail),
        .i_entry     (queue_entry),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

// File: dv/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for signed_int_to_decimal_ascii: numbers go in on a
// valid/ready channel and the decimal characters that come out are checked in order.
// Depends on itda_pkg and the signed_int_to_decimal_ascii top level only.
module signed_int_to_decimal_ascii_tb;
    import itda_pkg::*;

    // Longest stretch of cycles in which neither channel moves a request. The
    // slowest correct run waits out a long receiver stall plus the conversion of
    // an eleven-character number.
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 40;

    // One expected output character.
    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_ascii_char;

    // Tracks the characters still owed by the block. Each accepted number is
    // expanded into its decimal text right away, and every output request is
    // matched against the oldest character still pending.
    class decimal_char_tracker;
        t_ascii_char pending_chars[$];
        int          errors;

        function void add_number(logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] mag;
            logic [3:0]         digits[$];
            t_ascii_char        ch;
            bit                 negative;
            negative = value[VALUE_W-1];
            // Two's complement negation in 32 bits, so the most negative value
            // yields magnitude 2147483648 without overflow.
            mag = negative ? (~value + 1'b1) : value;
            // Least significant digit first; zero still gives one digit.
            do begin
                digits.push_front(4'(mag % 10));
                mag = mag / 10;
            end while (mag != 0);
            if (negative) begin
                ch.code = ASCII_MINUS;
                ch.last = 1'b0;
                pending_chars.push_back(ch);
            end
            foreach (digits[k]) begin
                ch.code = ASCII_ZERO + CHAR_W'(digits[k]);
                ch.last = (k == digits.size() - 1);
                pending_chars.push_back(ch);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] code, logic last);
            t_ascii_char want;
            if (pending_chars.size() == 0) begin
                $error("unexpected character: char_code %0d, last_char %0b", code, last);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (code !== want.code) begin
                $error("char_code mismatch: expected %0d, actual %0d", want.code, code);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_char mismatch: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [VALUE_W-1:0] i_value;
    logic               o_valid;
    logic               i_ready;
    logic [CHAR_W-1:0]  o_char_code;
    logic               o_last_char;

    decimal_char_tracker tracker = new;

    // Idle cycle count for the watchdog, and flags that switch off the random
    // gaps for whole stretches so that back-to-back traffic is covered too.
    int cycle_count;
    int idle_cycles;
    bit send_steady;
    bit recv_steady;

    // Numbers at the edges of the range and at the 1-2, 2-3 and 9-10 digit boundaries.
    int corner_values[$] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
        999999999, 1000000000, -999999999, -1000000000,
        2147483647, -2147483647, int'(32'h8000_0000), 2147483640,
        1111111111, -2000000000
    };

    signed_int_to_decimal_ascii uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap(bit steady);
        int roll;
        if (steady) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Random numbers spread evenly over the digit counts, so short and long
    // strings both show up often, with some fully random words and tiny values.
    function automatic logic [VALUE_W-1:0] pick_value();
        int                 roll;
        int                 ndig;
        longint             lo;
        longint             hi;
        longint             mag;
        logic [VALUE_W-1:0] word;
        roll = $urandom_range(0, 9);
        if (roll < 2) begin
            return $urandom;
        end else if (roll < 4) begin
            word = $urandom_range(0, 20);
        end else begin
            ndig = $urandom_range(1, 10);
            lo = (ndig == 1) ? 0 : 64'(10) ** (ndig - 1);
            hi = (ndig == 10) ? 64'd2147483647 : 64'(10) ** ndig - 1;
            mag = lo + longint'($urandom) % (hi - lo + 1);
            word = mag[VALUE_W-1:0];
        end
        return $urandom_range(0, 1) ? (~word + 1'b1) : word;
    endfunction

    // Presents one number, holds it until the block takes it, and then leaves
    // a random gap. Valid stays high across back-to-back requests.
    task automatic send_number(logic [VALUE_W-1:0] value);
        int gap;
        i_value <= value;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        tracker.add_number(value);
        gap = pick_gap(send_steady);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Every input is known from time zero, with reset asserted.
    initial begin
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        i_ready = 1'b0;
    end

    // Receiver: ready runs high for a random stretch and then stalls at random.
    initial begin
        int hold;
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            hold = $urandom_range(1, 8);
            i_ready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            stall = pick_gap(recv_steady);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Output requests are sampled at the clock edge, before any update that
    // the edge itself causes, so the check does not depend on event order.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_char(o_char_code, o_last_char);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        // The receiver runs without stalls in one of every four long stretches.
        recv_steady <= ((cycle_count / 1500) % 4) == 2;
    end

    initial begin
        cycle_count = 0;
        idle_cycles = 0;
        recv_steady = 1'b0;
    end

    // Watchdog: the run is abandoned once nothing has moved for too long.
    initial begin
        @(posedge i_clk);
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        send_steady = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed numbers first: zero, single digits, the 1-2, 2-3 and 9-10 digit-count
        // boundaries, both ends of the range and the most negative value.
        foreach (corner_values[n]) begin
            send_number(corner_values[n]);
        end

        // Random numbers; every fourth stretch of sixty is sent without gaps.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_steady = ((n / 60) % 4) == 1;
            send_number(pick_value());
        end
        i_valid <= 1'b0;

        // Wait for every owed character, then a little longer to catch extras.
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
